/* rtl/fpr_pkg.sv */
`timescale 1ns / 1ps
package fpr_pkg;
    localparam int ForceWidth = 16;
    localparam int TimeWidth = 32;
    localparam int DurWidth = 24;
    localparam int CfgIdxWidth = 3;
    localparam int CfgDataWidth = (DurWidth > ForceWidth) ? DurWidth : ForceWidth;

    localparam logic [CfgIdxWidth-1:0] CFG_DUR = 3'd0;
    localparam logic [CfgIdxWidth-1:0] CFG_FX = 3'd1;
    localparam logic [CfgIdxWidth-1:0] CFG_FY = 3'd2;
    localparam logic [CfgIdxWidth-1:0] CFG_FZ = 3'd3;
    localparam logic [CfgIdxWidth-1:0] CFG_MAX = 3'd4;

    localparam logic [1:0] MODE_TICK = 2'd0;
    localparam logic [1:0] MODE_START = 2'd1;
    localparam logic [1:0] MODE_ABORT = 2'd2;
    localparam logic [1:0] MODE_RAMP = 2'd3;

    typedef struct packed {
        logic [1:0]           mode;
        logic [TimeWidth-1:0] now_us;
        logic [DurWidth-1:0]  ramp_duration_us;
    } t_in;

    typedef struct packed {
        logic signed [ForceWidth-1:0] force_x;
        logic signed [ForceWidth-1:0] force_y;
        logic signed [ForceWidth-1:0] force_z;
        logic                         pulse_active;
    } t_out;

    typedef enum logic [3:0] {
        ST_IDLE, ST_CHECK, ST_SQ, ST_SQRT, ST_LIM, ST_RCHK, ST_RAMP, ST_DONE, ST_ZERO, ST_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic upd_state;
        logic sq_step;
        logic sqrt_init;
        logic sqrt_step;
        logic lim_init;
        logic ramp_init;
        logic div_step;
        logic zero_out;
        logic fill_out;
    } t_cmd;

    typedef struct packed {
        logic is_tick;
        logic active;
        logic expired;
        logic need_lim;
        logic ramping;
        logic ramp_over;
        logic sq_last;
        logic sqrt_last;
        logic div_last;
    } t_sts;
endpackage

/* rtl/fpr_ctrl.sv */
`timescale 1ns / 1ps
module fpr_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    output logic          o_valid,
    input  logic          i_ready,
    input  fpr_pkg::t_sts i_sts,
    output fpr_pkg::t_cmd o_cmd
);
    import fpr_pkg::*;

    t_state r_state, n_state;
    logic   r_ovalid, n_ovalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_valid = r_ovalid;
    assign o_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state  = r_state;
        n_ovalid = r_ovalid && !i_ready;
        o_cmd    = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (!i_sts.is_tick) begin
                    o_cmd.upd_state = 1'b1;
                    n_state         = ST_IDLE;
                end else if (!i_sts.active || i_sts.expired) begin
                    o_cmd.upd_state = 1'b1;
                    n_state         = ST_ZERO;
                end else begin
                    n_state = ST_SQ;
                end
            end
            ST_SQ: begin
                o_cmd.sq_step = 1'b1;
                if (i_sts.sq_last) begin
                    n_state = ST_LIM;
                end
            end
            ST_LIM: begin
                if (i_sts.need_lim) begin
                    o_cmd.sqrt_init = 1'b1;
                    n_state         = ST_SQRT;
                end else begin
                    n_state = ST_RCHK;
                end
            end
            ST_SQRT: begin
                if (i_sts.sqrt_last) begin
                    o_cmd.lim_init = 1'b1;
                    n_state        = ST_DONE;
                end else begin
                    o_cmd.sqrt_step = 1'b1;
                end
            end
            ST_DONE: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = ST_RCHK;
                end
            end
            ST_RCHK: begin
                if (!i_sts.ramping) begin
                    n_state = ST_OUT;
                end else if (i_sts.ramp_over) begin
                    o_cmd.upd_state = 1'b1;
                    n_state         = ST_ZERO;
                end else begin
                    o_cmd.ramp_init = 1'b1;
                    n_state         = ST_RAMP;
                end
            end
            ST_RAMP: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = ST_OUT;
                end
            end
            ST_ZERO: begin
                if (!r_ovalid || i_ready) begin
                    o_cmd.zero_out = 1'b1;
                    n_ovalid       = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            ST_OUT: begin
                if (!r_ovalid || i_ready) begin
                    o_cmd.fill_out = 1'b1;
                    n_ovalid       = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end
endmodule

/* rtl/fpr_dp.sv */
`timescale 1ns / 1ps
module fpr_dp (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [fpr_pkg::CfgIdxWidth-1:0]       i_cfg_idx,
    input  logic [fpr_pkg::CfgDataWidth-1:0]      i_cfg_data,
    input  logic [1:0]                            i_mode,
    input  logic [fpr_pkg::TimeWidth-1:0]         i_now_us,
    input  logic [fpr_pkg::DurWidth-1:0]          i_ramp_duration_us,
    input  fpr_pkg::t_cmd                         i_cmd,
    output fpr_pkg::t_sts                         o_sts,
    output logic signed [fpr_pkg::ForceWidth-1:0] o_fx,
    output logic signed [fpr_pkg::ForceWidth-1:0] o_fy,
    output logic signed [fpr_pkg::ForceWidth-1:0] o_fz,
    output logic                                  o_pact
);
    import fpr_pkg::*;

    localparam int FW   = ForceWidth;
    localparam int SQW  = 2 * FW + 2;
    localparam int NW   = (FW > DurWidth) ? FW : DurWidth;
    localparam int PW   = FW + NW;
    localparam int EW   = (TimeWidth > DurWidth) ? TimeWidth : DurWidth;
    localparam int CNTW = $clog2(PW + 1);

    logic [DurWidth-1:0]  r_dur;
    logic [FW-1:0]        r_f [3];
    logic [FW-1:0]        r_max;
    logic                 r_active, r_ramping;
    logic [TimeWidth-1:0] r_start, r_rstart;
    logic [DurWidth-1:0]  r_rlen;

    logic [1:0]           r_mode;
    logic [TimeWidth-1:0] r_now;
    logic [DurWidth-1:0]  r_rdur;

    logic [FW-1:0]  r_mag [3];
    logic           r_neg [3];
    logic [1:0]     r_sqi;
    logic [SQW-1:0] r_sum;

    logic [SQW-1:0] r_x, r_bit, r_root;

    logic [NW-1:0]   r_num, r_den;
    logic [PW-1:0]   r_rem;
    logic [PW-1:0]   r_quo;
    logic [1:0]      r_di;
    logic [CNTW-1:0] r_dcnt;

    logic [TimeWidth-1:0] el, rel;
    logic [2*FW-1:0]      sq;
    logic [2*FW-1:0]      maxsq;
    logic [SQW-1:0]       trial;
    logic [PW-1:0]        prod;
    logic [PW:0]          dv_t;
    logic                 dv_ge;
    logic [PW-1:0]        dv_q;
    logic [FW-1:0]        absf [3];

    assign el    = r_now - r_start;
    assign rel   = r_now - r_rstart;
    assign sq    = r_mag[r_sqi] * r_mag[r_sqi];
    assign maxsq = r_max * r_max;
    assign trial = r_root + r_bit;
    assign prod  = r_mag[r_di] * r_num;
    assign dv_t  = {r_rem, r_quo[PW-1]};
    assign dv_ge = dv_t >= (PW+1)'(r_den);
    assign dv_q  = {r_quo[PW-2:0], dv_ge};

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            absf[k] = r_f[k][FW-1] ? FW'(-r_f[k]) : r_f[k];
        end
    end

    assign o_sts.is_tick   = (r_mode == MODE_TICK);
    assign o_sts.active    = r_active;
    assign o_sts.expired   = EW'(el) >= EW'(r_dur);
    assign o_sts.need_lim  = r_sum > SQW'(maxsq);
    assign o_sts.ramping   = r_ramping;
    assign o_sts.ramp_over = EW'(rel) >= EW'(r_rlen);
    assign o_sts.sq_last   = (r_sqi == 2'd2);
    assign o_sts.sqrt_last = (r_bit == '0);
    assign o_sts.div_last  = (r_di == 2'd2) && (r_dcnt == CNTW'(PW));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dur     <= '0;
            r_f[0]    <= '0;
            r_f[1]    <= '0;
            r_f[2]    <= '0;
            r_max     <= '1;
            r_active  <= 1'b0;
            r_ramping <= 1'b0;
            r_start   <= '0;
            r_rstart  <= '0;
            r_rlen    <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_DUR: r_dur  <= i_cfg_data[DurWidth-1:0];
                    CFG_FX:  r_f[0] <= i_cfg_data[FW-1:0];
                    CFG_FY:  r_f[1] <= i_cfg_data[FW-1:0];
                    CFG_FZ:  r_f[2] <= i_cfg_data[FW-1:0];
                    CFG_MAX: r_max  <= i_cfg_data[FW-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.upd_state) begin
                case (r_mode)
                    MODE_START: begin
                        r_active  <= 1'b1;
                        r_ramping <= 1'b0;
                        r_start   <= r_now;
                    end
                    MODE_RAMP: begin
                        if (r_active && !r_ramping) begin
                            r_ramping <= 1'b1;
                            r_rstart  <= r_now;
                            r_rlen    <= r_rdur;
                        end
                    end
                    default: begin
                        r_active  <= 1'b0;
                        r_ramping <= 1'b0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= i_mode;
            r_now  <= i_now_us;
            r_rdur <= i_ramp_duration_us;
            r_sqi  <= '0;
            r_sum  <= '0;
            for (int k = 0; k < 3; k++) begin
                r_mag[k] <= absf[k];
                r_neg[k] <= r_f[k][FW-1];
            end
        end
        if (i_cmd.sq_step) begin
            r_sum <= r_sum + SQW'(sq);
            r_sqi <= r_sqi + 2'd1;
        end
        if (i_cmd.sqrt_init) begin
            r_x    <= r_sum;
            r_root <= '0;
            r_bit  <= SQW'(1) << (SQW - 2);
        end
        if (i_cmd.sqrt_step) begin
            if (r_x >= trial) begin
                r_x    <= r_x - trial;
                r_root <= (r_root >> 1) + r_bit;
            end else begin
                r_root <= r_root >> 1;
            end
            r_bit <= r_bit >> 2;
        end
        if (i_cmd.lim_init) begin
            r_di   <= '0;
            r_dcnt <= '0;
            r_num  <= NW'(r_max);
            r_den  <= NW'(r_root);
        end
        if (i_cmd.ramp_init) begin
            r_di   <= '0;
            r_dcnt <= '0;
            r_num  <= NW'(r_rlen - DurWidth'(rel));
            r_den  <= NW'(r_rlen);
        end
        if (i_cmd.div_step) begin
            if (r_dcnt == '0) begin
                r_rem  <= '0;
                r_quo  <= prod;
                r_dcnt <= CNTW'(1);
            end else begin
                r_rem <= dv_ge ? PW'(dv_t - (PW+1)'(r_den)) : PW'(dv_t);
                r_quo <= dv_q;
                if (r_dcnt == CNTW'(PW)) begin
                    r_mag[r_di] <= dv_q[FW-1:0];
                    r_dcnt      <= '0;
                    if (r_di != 2'd2) begin
                        r_di <= r_di + 2'd1;
                    end
                end else begin
                    r_dcnt <= r_dcnt + CNTW'(1);
                end
            end
        end
        if (i_cmd.zero_out) begin
            o_fx   <= '0;
            o_fy   <= '0;
            o_fz   <= '0;
            o_pact <= 1'b0;
        end
        if (i_cmd.fill_out) begin
            o_fx   <= r_neg[0] ? -$signed(r_mag[0]) : $signed(r_mag[0]);
            o_fy   <= r_neg[1] ? -$signed(r_mag[1]) : $signed(r_mag[1]);
            o_fz   <= r_neg[2] ? -$signed(r_mag[2]) : $signed(r_mag[2]);
            o_pact <= 1'b1;
        end
    end
endmodule

/* rtl/force_pulse_with_rampdown_core.sv */
`timescale 1ns / 1ps
// Timed force pulse with optional linear ramp-down.
// Input channel (i_in_valid/o_in_ready, i_in): mode 0 tick, 1 start,
// 2 abort, 3 begin ramp-down. Only ticks yield a transaction on the output
// channel (o_out_valid/i_out_ready, o_out): force vector and pulse_active.
// Configuration: i_cfg_we with i_cfg_idx/i_cfg_data, written while no
// transaction is in flight; 0 duration, 1..3 force x/y/z, 4 max force.
// One transaction is processed at a time; o_in_ready is high only when idle.
// A control item only updates the pulse state; an idle or expired tick gives
// a zero result. Over the magnitude limit, a square root and a bit-serial
// division per component scale the force; a running ramp adds another such
// division per component. A tick whose ramp has ended gives its zero result
// right after the limit step.
// Reset clears the pulse state and configuration registers (max force to all ones).
// A result waits in the output register while the receiver stalls; the next
// transaction is accepted, but the block holds before presenting another result.
module force_pulse_with_rampdown_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [fpr_pkg::CfgIdxWidth-1:0]  i_cfg_idx,
    input  logic [fpr_pkg::CfgDataWidth-1:0] i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  fpr_pkg::t_in                     i_in,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output fpr_pkg::t_out                    o_out
);
    import fpr_pkg::*;

    t_cmd cmd;
    t_sts sts;

    fpr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    fpr_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .i_mode             (i_in.mode),
        .i_now_us           (i_in.now_us),
        .i_ramp_duration_us (i_in.ramp_duration_us),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .o_fx               (o_out.force_x),
        .o_fy               (o_out.force_y),
        .o_fz               (o_out.force_z),
        .o_pact             (o_out.pulse_active)
    );
endmodule
